### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/isp_pkg.sv
// ----------------------------------------------------------------------------
// isp_pkg
// Shared constants, codes and types of the interpolating sample player.
// ----------------------------------------------------------------------------
package isp_pkg;

    // Table geometry (TABLE_DEPTH is a power of two)
    localparam int TABLE_DEPTH = 65536;
    localparam int FRAC_BITS   = 10;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int POS_W       = ADDR_W + FRAC_BITS;
    localparam int SPAN_W      = POS_W + 1;
    localparam int NP_W        = POS_W + 2;
    localparam int MAG_W       = NP_W - 1;
    localparam int MOD_CNT_W   = $clog2(MAG_W + 1);

    // Field widths
    localparam int SAMPLE_W     = 16;
    localparam int RATE_W       = 16;
    localparam int ADDR_FIELD_W = 16;
    localparam int CFG_COUNT_W  = 17;
    localparam int CMD_W        = 2;
    localparam int S_TDATA_W    = ADDR_FIELD_W + SAMPLE_W;
    localparam int M_TUSER_W    = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 17;
    localparam int CMP_W        = (CNT_W > CFG_COUNT_W) ? CNT_W : CFG_COUNT_W;

    // Register reset values
    localparam logic signed [RATE_W-1:0] RATE_RESET  = RATE_W'(1024);
    localparam logic [CFG_COUNT_W-1:0]   COUNT_RESET = CFG_COUNT_W'(65536);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_START = 2'd2,
        CMD_STOP  = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE  = 2'd0,
        CFG_LOOP  = 2'd1,
        CFG_COUNT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                 active;
        logic                 playing;
        logic                 finished;
        logic [FRAC_BITS-1:0] frac;
    } t_tick_info;

    typedef struct packed {
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [SPAN_W-1:0] span;
    } t_mod_req;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   addr;
        logic [SAMPLE_W-1:0] data;
    } t_ram_wr;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
    } t_ram_rd;

    // Clamp the sample count to [2, TABLE_DEPTH]
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_COUNT_W-1:0] c);
        logic [CMP_W-1:0] cw;
        cw = CMP_W'(c);
        if (cw < CMP_W'(2)) begin
            return CNT_W'(2);
        end else if (cw > CMP_W'(TABLE_DEPTH)) begin
            return CNT_W'(TABLE_DEPTH);
        end else begin
            return CNT_W'(cw);
        end
    endfunction

endpackage

### hw/rtl/isp_ram.sv
// ----------------------------------------------------------------------------
// isp_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module isp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/isp_mod.sv
// ----------------------------------------------------------------------------
// isp_mod
// Bit-serial floor remainder of a signed position by the table span.
// ----------------------------------------------------------------------------
module isp_mod import isp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_mod_req         i_req,
    output logic             o_busy,
    output logic             o_done,
    output logic [POS_W-1:0] o_rem
);

    logic                 r_busy;
    logic                 r_fix;
    logic [MOD_CNT_W-1:0] r_cnt;
    logic [MAG_W-1:0]     r_mag;
    logic [SPAN_W-1:0]    r_rem;
    logic [SPAN_W-1:0]    r_span;
    logic                 r_neg;

    logic [SPAN_W:0]   w_trial;
    logic              w_ge;
    logic [SPAN_W-1:0] n_rem;

    // One quotient bit per cycle; remainder stays below the span
    always_comb begin
        w_trial = {r_rem, r_mag[MAG_W-1]};
        w_ge    = w_trial >= {1'b0, r_span};
        n_rem   = w_ge ? SPAN_W'(w_trial - {1'b0, r_span}) : SPAN_W'(w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == MOD_CNT_W'(MAG_W - 1)) begin
                r_busy <= 1'b0;
                r_fix  <= 1'b1;
            end
        end else begin
            r_fix <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag  <= i_req.mag;
            r_span <= i_req.span;
            r_neg  <= i_req.neg;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_mag <= {r_mag[MAG_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    // Fold a negative operand back into [0, span)
    assign o_rem  = (r_neg && (r_rem != '0)) ? POS_W'(r_span - r_rem) : POS_W'(r_rem);
    assign o_busy = r_busy || r_fix;
    assign o_done = r_fix;

endmodule

### hw/rtl/isp_ctrl.sv
// ----------------------------------------------------------------------------
// isp_ctrl
// Command decode, play position accumulator and table read/write addressing.
// ----------------------------------------------------------------------------
module isp_ctrl import isp_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  t_cmd                           i_cmd,
    input  logic [ADDR_FIELD_W-1:0]        i_address,
    input  logic signed [SAMPLE_W-1:0]     i_sample_value,
    input  logic signed [RATE_W-1:0]       i_rate,
    input  logic                           i_loop,
    input  logic [CFG_COUNT_W-1:0]         i_count,
    output logic                           o_busy,
    output t_ram_wr                        o_wr,
    output t_ram_rd                        o_rd,
    output t_tick_info                     o_info
);

    logic [POS_W-1:0] r_position;
    logic [POS_W-1:0] n_position;
    logic             r_play;
    logic             n_play;

    logic [CNT_W-1:0]         w_n;
    logic [CNT_W-1:0]         w_nm1;
    logic [ADDR_W-1:0]        w_ip;
    logic [ADDR_W-1:0]        w_nx;
    logic [FRAC_BITS-1:0]     w_frac;
    logic [SPAN_W-1:0]        w_span_u;
    logic signed [NP_W-1:0]   w_np;
    logic signed [NP_W-1:0]   w_end;
    logic signed [NP_W-1:0]   w_span;
    logic signed [NP_W-1:0]   w_wrapped;
    logic signed [NP_W-1:0]   w_wrap_abs;
    logic                     w_past_end;
    logic                     w_past_start;
    logic                     w_out_rng;
    logic                     w_fin;
    logic                     w_mod_start;
    logic                     w_mod_busy;
    logic                     w_mod_done;
    logic [POS_W-1:0]         w_mod_rem;
    t_mod_req                 w_mod_req;

    always_comb begin
        w_n      = clamp_count(i_count);
        w_nm1    = w_n - 1'b1;
        w_ip     = r_position[POS_W-1:FRAC_BITS];
        w_frac   = r_position[FRAC_BITS-1:0];
        w_nx     = ({1'b0, w_ip} >= w_nm1) ? '0 : w_ip + 1'b1;
        w_span_u = {w_n, {FRAC_BITS{1'b0}}};

        w_np     = $signed({2'b00, r_position}) + NP_W'(i_rate);
        w_end    = $signed(NP_W'({w_nm1, {FRAC_BITS{1'b0}}}));
        w_span   = $signed(NP_W'(w_span_u));

        w_past_end   = w_np >= w_end;
        w_past_start = w_np < 0;
        w_wrapped    = w_past_end ? w_np - w_end : w_np + w_span;
        w_out_rng    = (w_wrapped < 0) || (w_wrapped >= w_span);
        w_wrap_abs   = w_wrapped[NP_W-1] ? -w_wrapped : w_wrapped;

        w_mod_req.neg  = w_wrapped[NP_W-1];
        w_mod_req.mag  = MAG_W'(w_wrap_abs);
        w_mod_req.span = w_span_u;
    end

    // Next position and play flag
    always_comb begin
        n_position  = r_position;
        n_play      = r_play;
        w_fin       = 1'b0;
        w_mod_start = 1'b0;
        if (w_mod_done) begin
            n_position = w_mod_rem;
        end
        if (i_accept) begin
            unique case (i_cmd)
                CMD_LOAD: begin
                end
                CMD_TICK: begin
                    if (r_play) begin
                        if (w_past_end || w_past_start) begin
                            if (i_loop) begin
                                if (w_out_rng) begin
                                    w_mod_start = 1'b1;
                                end else begin
                                    n_position = POS_W'(w_wrapped);
                                end
                            end else begin
                                n_position = '0;
                                n_play     = 1'b0;
                                w_fin      = 1'b1;
                            end
                        end else begin
                            n_position = POS_W'(w_np);
                        end
                    end
                end
                CMD_START: begin
                    n_play = 1'b1;
                end
                CMD_STOP: begin
                    n_play     = 1'b0;
                    n_position = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_play     <= 1'b1;
        end else begin
            r_position <= n_position;
            r_play     <= n_play;
        end
    end

    isp_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_req   (w_mod_req),
        .o_busy  (w_mod_busy),
        .o_done  (w_mod_done),
        .o_rem   (w_mod_rem)
    );

    always_comb begin
        o_wr.we   = i_accept && (i_cmd == CMD_LOAD);
        o_wr.addr = ADDR_W'(i_address);
        o_wr.data = i_sample_value;

        o_rd.re     = i_accept && (i_cmd == CMD_TICK);
        o_rd.addr_a = w_ip;
        o_rd.addr_b = w_nx;

        o_info.active   = r_play;
        o_info.playing  = r_play && !w_fin;
        o_info.finished = w_fin;
        o_info.frac     = w_frac;
    end

    assign o_busy = w_mod_busy;

endmodule

### hw/rtl/isp_interp.sv
// ----------------------------------------------------------------------------
// isp_interp
// Interpolation pipeline behind the table reads, with output register.
// ----------------------------------------------------------------------------
module isp_interp import isp_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  t_tick_info                 i_info,
    input  logic signed [SAMPLE_W-1:0] i_rd_a,
    input  logic signed [SAMPLE_W-1:0] i_rd_b,
    input  logic                       i_m_tready,
    output logic                       o_ready,
    output logic                       o_valid,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic                       o_playing,
    output logic                       o_finished
);

    localparam int PROD_W = SAMPLE_W + FRAC_BITS + 2;
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3;

    t_tick_info                 r_info1;
    t_tick_info                 r_info2;
    logic signed [SAMPLE_W-1:0] r_a2;
    logic signed [PROD_W-1:0]   r_prod2;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_playing;
    logic                       r_finished;

    logic signed [SAMPLE_W:0]    w_diff;
    logic signed [FRAC_BITS:0]   w_frac_s;
    logic signed [PROD_W-1:0]    w_prod;
    logic signed [PROD_W-1:0]    w_sum;

    assign w_rdy3 = !r_v3 || i_m_tready;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    // a + floor(((b - a) * f + half) / 2^F)
    always_comb begin
        w_diff   = $signed({i_rd_b[SAMPLE_W-1], i_rd_b}) - $signed({i_rd_a[SAMPLE_W-1], i_rd_a});
        w_frac_s = $signed({1'b0, r_info1.frac});
        w_prod   = w_diff * w_frac_s + HALF;
        w_sum    = PROD_W'(r_a2) + (r_prod2 >>> FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_push;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_info1 <= i_info;
        end
        if (w_rdy2 && r_v1) begin
            r_info2 <= r_info1;
            r_a2    <= i_rd_a;
            r_prod2 <= w_prod;
        end
        if (w_rdy3 && r_v2) begin
            r_sample   <= r_info2.active ? SAMPLE_W'(w_sum) : '0;
            r_playing  <= r_info2.playing;
            r_finished <= r_info2.finished;
        end
    end

    assign o_ready    = w_rdy1;
    assign o_valid    = r_v3;
    assign o_sample   = r_sample;
    assign o_playing  = r_playing;
    assign o_finished = r_finished;

endmodule

### hw/rtl/interpolating_sample_player.sv
// ----------------------------------------------------------------------------
// interpolating_sample_player
// Variable-rate playback of a stored sample table with linear interpolation.
// ----------------------------------------------------------------------------
// The block takes requests on its input stream and returns a tick result via
// the table read, product and output registers; load, start and stop requests
// give no result. Sustained rate is one request per cycle while the output
// takes results: the position accumulator adds the rate once per tick and the
// two table reads (two RAM copies written in parallel, one per read address)
// plus a two-stage interpolation pipeline trail behind it. The other stall is
// a looping tick whose wrapped position still lies outside the table span (a
// step larger than the table, or a position left beyond a lowered sample
// count): the position is then reduced by a bit-serial remainder unit and the
// input stays stalled until it is done. The table is undefined until loaded,
// so there is no clearing pass after reset. The output register lets the
// input keep taking requests while a result waits. Configuration writes are
// always ready and belong to quiet periods only.
// ----------------------------------------------------------------------------
module interpolating_sample_player import isp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [S_TDATA_W-1:0]   i_s_tdata,   // [15:0] address, [31:16] sample_value
    input  logic [CMD_W-1:0]       i_s_tuser,   // [1:0] command
    // Output stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [SAMPLE_W-1:0]    o_m_tdata,   // [15:0] sample
    output logic [M_TUSER_W-1:0]   o_m_tuser,   // [0] playing, [1] finished
    // Configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // Configuration registers
    logic signed [RATE_W-1:0]  r_rate;
    logic                      r_loop;
    logic [CFG_COUNT_W-1:0]    r_count;

    logic       w_accept;
    logic       w_busy;
    logic       w_pipe_ready;
    t_cmd       w_cmd;
    t_ram_wr    w_wr;
    t_ram_rd    w_rd;
    t_tick_info w_info;

    logic [SAMPLE_W-1:0]        w_rd_a;
    logic [SAMPLE_W-1:0]        w_rd_b;
    logic signed [SAMPLE_W-1:0] w_sample;
    logic                       w_playing;
    logic                       w_finished;

    // Configuration port never stalls
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate  <= RATE_RESET;
            r_loop  <= 1'b1;
            r_count <= COUNT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RATE:  r_rate  <= $signed(i_cfg_data[RATE_W-1:0]);
                CFG_LOOP:  r_loop  <= i_cfg_data[0];
                CFG_COUNT: r_count <= i_cfg_data[CFG_COUNT_W-1:0];
                default: begin
                    // unused index: drop the write
                end
            endcase
        end
    end

    // Hold the input while the remainder unit runs or the pipeline is full
    assign o_s_tready = !w_busy && w_pipe_ready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_cmd      = t_cmd'(i_s_tuser);

    isp_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_cmd          (w_cmd),
        .i_address      (i_s_tdata[ADDR_FIELD_W-1:0]),
        .i_sample_value ($signed(i_s_tdata[S_TDATA_W-1:ADDR_FIELD_W])),
        .i_rate         (r_rate),
        .i_loop         (r_loop),
        .i_count        (r_count),
        .o_busy         (w_busy),
        .o_wr           (w_wr),
        .o_rd           (w_rd),
        .o_info         (w_info)
    );

    // Two copies of the table: one read port each, written together
    isp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_wr.we),
        .i_waddr (w_wr.addr),
        .i_wdata (w_wr.data),
        .i_re    (w_rd.re),
        .i_raddr (w_rd.addr_a),
        .o_rdata (w_rd_a)
    );

    isp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_wr.we),
        .i_waddr (w_wr.addr),
        .i_wdata (w_wr.data),
        .i_re    (w_rd.re),
        .i_raddr (w_rd.addr_b),
        .o_rdata (w_rd_b)
    );

    isp_interp u_interp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_rd.re),
        .i_info     (w_info),
        .i_rd_a     ($signed(w_rd_a)),
        .i_rd_b     ($signed(w_rd_b)),
        .i_m_tready (i_m_tready),
        .o_ready    (w_pipe_ready),
        .o_valid    (o_m_tvalid),
        .o_sample   (w_sample),
        .o_playing  (w_playing),
        .o_finished (w_finished)
    );

    assign o_m_tdata = w_sample;
    assign o_m_tuser = {w_finished, w_playing};

endmodule

### hw/rtl/isp_chk.sv
// ----------------------------------------------------------------------------
// isp_chk
// Port-level checks of the sample player output stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module isp_chk import isp_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [SAMPLE_W-1:0]    o_m_tdata,
    input logic [M_TUSER_W-1:0]   o_m_tuser
);

    // A finishing tick always reports playback stopped
    `ASSERT_IMP(a_fin_stops, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[1], !o_m_tuser[0])

    // A tick while stopped gives silence
    `ASSERT_IMP(a_stopped_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser == '0, o_m_tdata == '0)

    // A result is held until taken
    `ASSERT_NXT(a_hold_valid, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid)

endmodule

bind interpolating_sample_player isp_chk u_isp_chk (.*);

### verif/interpolating_sample_player_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interpolating_sample_player_tb
// Streams load, tick, start and stop requests into the sample player. A
// scoreboard predicts each tick result and checks the output stream.
// ----------------------------------------------------------------------------
// A short directed part runs first. It covers the reset settings, sample and
// address extremes, every command, a tick while stopped, the wrap below zero
// to the last entry, the next index wrapping to entry 0, a position left past
// a lowered count, non-looping end of play, clamped counts and the remainder
// path for steps larger than the table. Random phases follow, each with its
// own register settings. Before every tick the table entries that the tick
// will read are loaded if they never were, so no undefined entry is read.
// Both streams idle at random, except during one phase that runs flat out.
// ----------------------------------------------------------------------------
module interpolating_sample_player_tb;
    import isp_pkg::*;

    localparam int SETTLE_CYCLES  = 32;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_REQUESTS = 125;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                playing;
        logic                finished;
    } t_tick_result;

    // Tracks the player state and holds the tick results still owed.
    class t_playback_scoreboard;
        logic signed [SAMPLE_W-1:0] sample_mem [TABLE_DEPTH];
        bit                         loaded     [TABLE_DEPTH];
        longint                     pos;
        bit                         play_on;
        longint                     step;
        bit                         wrap_on;
        longint                     count_reg;
        t_tick_result               due_samples [$];
        int                         mismatches;

        function new();
            pos       = 0;
            play_on   = 1'b1;
            step      = 1024;
            wrap_on   = 1'b1;
            count_reg = 65536;
            mismatches = 0;
        endfunction

        function longint eff_count();
            if (count_reg < 2) return 2;
            if (count_reg > TABLE_DEPTH) return TABLE_DEPTH;
            return count_reg;
        endfunction

        // Table entries read by the next tick
        function void tick_reads(output int unsigned ia, output int unsigned ib);
            longint n;
            n  = eff_count();
            ia = int'((pos >> FRAC_BITS) % TABLE_DEPTH);
            ib = (ia >= n - 1) ? 0 : ia + 1;
        endfunction

        function void note_config(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_RATE:  step      = longint'($signed(data[RATE_W-1:0]));
                CFG_LOOP:  wrap_on   = data[0];
                CFG_COUNT: count_reg = longint'(data);
                default: ;
            endcase
        endfunction

        function void note_request(t_cmd cmd, logic [ADDR_FIELD_W-1:0] addr,
                                   logic [SAMPLE_W-1:0] value);
            t_tick_result res;
            int unsigned  ia, ib;
            longint       n, a, b, frac, acc, span, stop_at, np;
            case (cmd)
                CMD_LOAD: begin
                    sample_mem[addr % TABLE_DEPTH] = value;
                    loaded[addr % TABLE_DEPTH]     = 1'b1;
                end
                CMD_START: play_on = 1'b1;
                CMD_STOP: begin
                    play_on = 1'b0;
                    pos     = 0;
                end
                CMD_TICK: begin
                    res = '{sample: '0, playing: 1'b0, finished: 1'b0};
                    if (play_on) begin
                        // blend the two entries, round half up
                        n = eff_count();
                        tick_reads(ia, ib);
                        a    = longint'(sample_mem[ia]);
                        b    = longint'(sample_mem[ib]);
                        frac = pos & ((longint'(1) << FRAC_BITS) - 1);
                        acc  = a * ((longint'(1) << FRAC_BITS) - frac) + b * frac
                               + (longint'(1) << (FRAC_BITS - 1));
                        res.sample = SAMPLE_W'(acc >>> FRAC_BITS);

                        // advance, then handle either end
                        span    = n << FRAC_BITS;
                        stop_at = (n - 1) << FRAC_BITS;
                        np      = pos + step;
                        if (np >= stop_at || np < 0) begin
                            if (wrap_on) begin
                                np = (np >= stop_at) ? np - stop_at : np + span;
                                if (np < 0 || np >= span) begin
                                    np = np % span;
                                    if (np < 0) np += span;
                                end
                            end else begin
                                np           = 0;
                                play_on      = 1'b0;
                                res.finished = 1'b1;
                            end
                        end
                        pos         = np;
                        res.playing = play_on;
                    end
                    due_samples.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [SAMPLE_W-1:0] got_sample, logic got_play,
                                   logic got_fin);
            t_tick_result want;
            if (due_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] unexpected result: sample %0d playing %b finished %b",
                             $realtime, $signed(got_sample), got_play, got_fin);
                return;
            end
            want = due_samples.pop_front();
            if (got_sample !== want.sample || got_play !== want.playing ||
                got_fin !== want.finished) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"[%0t] mismatch: sample %0d exp %0d, playing %b exp %b, ",
                              "finished %b exp %b"}, $realtime, $signed(got_sample),
                             $signed(want.sample), got_play, want.playing, got_fin,
                             want.finished);
            end
        endfunction

        function int pending();
            return due_samples.size();
        endfunction
    endclass

    logic                   i_clk       = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata     = '0;
    logic [CMD_W-1:0]       s_tuser     = '0;
    logic                   m_tready    = 1'b0;
    logic                   cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;

    logic                   s_tready;
    logic                   m_tvalid;
    logic [SAMPLE_W-1:0]    m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   cfg_ready;

    // Output handshake as seen just before the next rising edge
    bit                     out_fire   = 1'b0;
    logic [SAMPLE_W-1:0]    out_sample = '0;
    logic [M_TUSER_W-1:0]   out_flags  = '0;

    int                     idle_pct   = 22;
    t_playback_scoreboard   playback   = new();

    always #6 i_clk = ~i_clk;

    interpolating_sample_player dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),    // [15:0] address, [31:16] sample_value
        .i_s_tuser   (s_tuser),    // [1:0] command
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),    // [15:0] sample
        .o_m_tuser   (m_tuser),    // [0] playing, [1] finished
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Sample the output side mid-cycle, where nothing is changing.
    always @(negedge i_clk) begin
        out_fire   = rst_n && m_tvalid === 1'b1 && m_tready;
        out_sample = m_tdata;
        out_flags  = m_tuser;
    end

    // Check the result taken at this edge and stall the output at random.
    always @(posedge i_clk) begin
        if (out_fire) playback.check_result(out_sample, out_flags[0], out_flags[1]);
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    // Offer one request, with a random gap first, and hold it until taken.
    task automatic send_req(t_cmd cmd, logic [ADDR_FIELD_W-1:0] addr,
                            logic [SAMPLE_W-1:0] value);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {value, addr};
        s_tuser  <= cmd;
        @(negedge i_clk);
        while (s_tready !== 1'b1) @(negedge i_clk);
        @(posedge i_clk);
        playback.note_request(cmd, addr, value);
    endtask

    // Load any entry the tick would read that was never written, then tick.
    task automatic send_tick();
        int unsigned ia, ib;
        if (playback.play_on) begin
            playback.tick_reads(ia, ib);
            if (!playback.loaded[ia])
                send_req(CMD_LOAD, ADDR_FIELD_W'(ia), SAMPLE_W'($urandom));
            if (!playback.loaded[ib])
                send_req(CMD_LOAD, ADDR_FIELD_W'(ib), SAMPLE_W'($urandom));
        end
        send_req(CMD_TICK, ADDR_FIELD_W'($urandom), SAMPLE_W'($urandom));
    endtask

    // Drop the input, wait for every owed result, let the pipeline and the
    // remainder unit empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (playback.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
        while (cfg_ready !== 1'b1) @(negedge i_clk);
        @(posedge i_clk);
        playback.note_config(idx, data);
    endtask

    // Write all three registers back to back; unused upper bits are random.
    task automatic configure(logic [RATE_W-1:0] rate_v, logic loop_v,
                             logic [CFG_COUNT_W-1:0] count_v);
        write_reg(CFG_RATE, {1'($urandom), rate_v});
        write_reg(CFG_LOOP, {16'($urandom), loop_v});
        write_reg(CFG_COUNT, count_v);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_config();
        logic [RATE_W-1:0]      r;
        logic [CFG_COUNT_W-1:0] c;
        int                     pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            r = RATE_W'($urandom_range(3000));
            if ($urandom_range(1)) r = -r;
        end else if (pick < 65) begin
            r = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        end else begin
            r = RATE_W'($urandom);
        end
        // mostly short tables, so the ends come around often
        pick = $urandom_range(99);
        if (pick < 50)      c = CFG_COUNT_W'($urandom_range(40, 2));
        else if (pick < 65) c = CFG_COUNT_W'($urandom_range(1));
        else if (pick < 80) c = $urandom_range(1) ? 17'd65536 : 17'h1FFFF;
        else                c = CFG_COUNT_W'($urandom);
        configure(r, 1'($urandom), c);
    endtask

    task automatic random_phase(int requests);
        int                      pick;
        longint                  n;
        logic [ADDR_FIELD_W-1:0] addr;
        logic [SAMPLE_W-1:0]     value;
        repeat (requests) begin
            pick  = $urandom_range(99);
            n     = playback.eff_count();
            addr  = ($urandom_range(99) < 70) ? ADDR_FIELD_W'($urandom_range(n - 1))
                                              : ADDR_FIELD_W'($urandom);
            value = ($urandom_range(99) < 10) ? ($urandom_range(1) ? 16'h7FFF : 16'h8000)
                                              : SAMPLE_W'($urandom);
            if (!playback.play_on && pick < 35) send_req(CMD_START, addr, value);
            else if (pick < 60)                 send_tick();
            else if (pick < 85)                 send_req(CMD_LOAD, addr, value);
            else if (pick < 93)                 send_req(CMD_START, addr, value);
            else                                send_req(CMD_STOP, addr, value);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;

        // Reset settings: unit rate, looping, full table.
        send_req(CMD_LOAD, 16'd0, 16'h7FFF);
        send_req(CMD_LOAD, 16'd1, 16'h8000);
        send_req(CMD_LOAD, 16'hFFFF, 16'hFFFF);
        send_req(CMD_LOAD, 16'd2, 16'h0000);
        send_tick();
        send_tick();
        send_req(CMD_STOP, 16'h0000, 16'h0000);
        send_tick();                            // stopped: zero result
        send_req(CMD_START, 16'hFFFF, 16'hFFFF);

        // Half-step backwards: wrap below zero onto the last entry,
        // whose next index is entry 0.
        settle();
        configure(16'hFE00, 1'b1, 17'd65536);
        repeat (3) send_tick();

        // Count lowered under the position, no looping: play ends.
        settle();
        configure(16'h7FFF, 1'b0, 17'd3);
        send_tick();
        send_tick();
        send_req(CMD_START, 16'h0000, 16'h0000);
        send_tick();

        // Count below the minimum, step far beyond the table: remainder path.
        settle();
        configure(16'h7FFF, 1'b1, 17'd0);
        send_req(CMD_START, 16'h0000, 16'h0000);
        repeat (3) send_tick();

        // Count above the table depth, largest backward step.
        settle();
        configure(16'h8000, 1'b1, 17'h1FFFF);
        repeat (2) send_tick();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            random_config();
            // one phase runs with no idling on either side
            idle_pct = (ph == 3) ? 0 : 22;
            random_phase(PHASE_REQUESTS);
        end

        settle();
        if (playback.mismatches == 0 && playback.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Hard stop well past the slowest correct run.
    initial begin
        #10ms;
        $display("simulation failed");
        $finish;
    end

endmodule

### interpolating_sample_player.f
+incdir+hw/rtl
hw/rtl/isp_pkg.sv
hw/rtl/isp_ram.sv
hw/rtl/isp_mod.sv
hw/rtl/isp_ctrl.sv
hw/rtl/isp_interp.sv
hw/rtl/interpolating_sample_player.sv
hw/rtl/isp_chk.sv
verif/interpolating_sample_player_tb.sv
